// ===== rtl/utv_pkg.sv =====
`timescale 1ns / 1ps
// utv_pkg: shared types, constants and widths for the UTF-8 text validator.
// No dependencies; used by every module of the block and by its checker.

package utv_pkg;

    // Byte counter width (saturating count of the current text).
    localparam int COUNT_BITS = 25;
    // max_length register width.
    localparam int LEN_W      = 25;
    // Width used for the length compare; wide enough for either operand.
    localparam int CMP_W      = 33;

    // Configuration bus.
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;
    localparam logic REG_IDX_MAX_LENGTH = 1'b0;   // paddr[2] of max_length
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(1048576);

    // Verdict codes.
    typedef enum logic [2:0] {
        VERDICT_VALID = 3'd0,
        VERDICT_LONG  = 3'd1,
        VERDICT_NUL   = 3'd2,
        VERDICT_CTRL  = 3'd3,
        VERDICT_UTF8  = 3'd4
    } t_verdict;

    // Byte values that bound lead and continuation ranges.
    localparam logic [7:0] LEAD2_LO  = 8'hc2;
    localparam logic [7:0] LEAD2_HI  = 8'hdf;
    localparam logic [7:0] LEAD3_LO  = 8'he0;
    localparam logic [7:0] LEAD3_HI  = 8'hef;
    localparam logic [7:0] LEAD4_LO  = 8'hf0;
    localparam logic [7:0] LEAD4_HI  = 8'hf4;
    localparam logic [7:0] LEAD_SURR = 8'hed;
    localparam logic [7:0] E0_MIN    = 8'ha0;
    localparam logic [7:0] ED_MAX    = 8'h9f;
    localparam logic [7:0] F0_MIN    = 8'h90;
    localparam logic [7:0] F4_MAX    = 8'h8f;
    localparam logic [7:0] CHR_DEL   = 8'h7f;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0a;
    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // Open multi-byte sequence state.
    typedef struct packed {
        logic [1:0] pend;      // continuation bytes still expected
        logic [7:0] lead;      // lead byte of the open sequence
        logic       second;    // next byte is the first continuation
    } t_seq_state;

endpackage

// ===== rtl/utv_apb_regs.sv =====
`timescale 1ns / 1ps
// utv_apb_regs: APB-style register file holding max_length.
// Depends on utv_pkg.

module utv_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [utv_pkg::APB_AW-1:0]    paddr,
    input  logic [utv_pkg::APB_DW-1:0]    pwdata,
    output logic [utv_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [utv_pkg::LEN_W-1:0]     o_max_length
);

    logic [utv_pkg::LEN_W-1:0] r_max_length;
    logic [utv_pkg::LEN_W-1:0] n_max_length;
    logic                      sel_len;

    assign sel_len = (paddr[2] == utv_pkg::REG_IDX_MAX_LENGTH);
    assign pready  = 1'b1;

    always_comb begin
        n_max_length = r_max_length;
        if (psel && penable && pwrite && sel_len) begin
            n_max_length = pwdata[utv_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= utv_pkg::MAX_LENGTH_RST;
        end else begin
            r_max_length <= n_max_length;
        end
    end

    assign prdata       = sel_len ? utv_pkg::APB_DW'(r_max_length) : '0;
    assign o_max_length = r_max_length;

endmodule

// ===== rtl/utv_seq_check.sv =====
`timescale 1ns / 1ps
// utv_seq_check: per-byte UTF-8 / control-byte check and sequence update.
// Pure combinational; depends on utv_pkg.

module utv_seq_check (
    input  logic [7:0]          i_byte,
    input  utv_pkg::t_seq_state i_seq,
    output utv_pkg::t_verdict   o_err,
    output utv_pkg::t_seq_state o_seq
);

    logic cont_bad;
    logic limit_bad;

    always_comb begin
        limit_bad = 1'b0;
        if (i_seq.second) begin
            limit_bad = ((i_seq.lead == utv_pkg::LEAD3_LO)  && (i_byte < utv_pkg::E0_MIN))
                     || ((i_seq.lead == utv_pkg::LEAD_SURR) && (i_byte > utv_pkg::ED_MAX))
                     || ((i_seq.lead == utv_pkg::LEAD4_LO)  && (i_byte < utv_pkg::F0_MIN))
                     || ((i_seq.lead == utv_pkg::LEAD4_HI)  && (i_byte > utv_pkg::F4_MAX));
        end
        cont_bad = (i_byte[7:6] != utv_pkg::CONT_TAG) || limit_bad;

        o_err = utv_pkg::VERDICT_VALID;
        o_seq = i_seq;

        if (i_seq.pend != 2'd0) begin
            // inside a sequence: continuation check only
            if (cont_bad) begin
                o_err = utv_pkg::VERDICT_UTF8;
            end else begin
                o_seq.pend   = i_seq.pend - 2'd1;
                o_seq.second = 1'b0;
            end
        end else if (i_byte == utv_pkg::CHR_NUL) begin
            o_err = utv_pkg::VERDICT_NUL;
        end else if (!i_byte[7]) begin
            if ((i_byte == utv_pkg::CHR_DEL) ||
                ((i_byte < utv_pkg::CHR_SPACE) && (i_byte != utv_pkg::CHR_TAB) &&
                 (i_byte != utv_pkg::CHR_CR) && (i_byte != utv_pkg::CHR_LF))) begin
                o_err = utv_pkg::VERDICT_CTRL;
            end
        end else if ((i_byte >= utv_pkg::LEAD2_LO) && (i_byte <= utv_pkg::LEAD2_HI)) begin
            o_seq = '{pend: 2'd1, lead: i_byte, second: 1'b1};
        end else if ((i_byte >= utv_pkg::LEAD3_LO) && (i_byte <= utv_pkg::LEAD3_HI)) begin
            o_seq = '{pend: 2'd2, lead: i_byte, second: 1'b1};
        end else if ((i_byte >= utv_pkg::LEAD4_LO) && (i_byte <= utv_pkg::LEAD4_HI)) begin
            o_seq = '{pend: 2'd3, lead: i_byte, second: 1'b1};
        end else begin
            o_err = utv_pkg::VERDICT_UTF8;   // stray continuation, C0/C1, F5-FF
        end
    end

endmodule

// ===== rtl/utf8_text_validator.sv =====
`timescale 1ns / 1ps
// utf8_text_validator: top level of the strict UTF-8 text validator.
// Depends on utv_pkg, utv_apb_regs and utv_seq_check.

// Usage
//   Input channel (i_valid / o_stall): one text byte per transfer, with
//   i_last_byte set on the final byte of a text. A transfer happens at a
//   rising edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall): one verdict per text, produced only
//   for the final byte: 0 valid, 1 too long, 2 NUL, 3 control, 4 bad UTF-8.
//   Config: APB-style port, max_length at byte address 0 (25 bits).
// Timing
//   A byte is latched in the input register and checked there; the verdict
//   of a text lands in the output register when its final byte leaves the
//   check stage, and o_valid shows it from there. Throughput is one byte
//   per cycle while o_stall is low, set by the check stage's state update.
// Reset (synchronous, active low) empties both registers, clears the text
//   state and loads max_length with 1048576.
// Stalls: while a verdict waits under i_stall, ordinary bytes still flow
//   through the check stage; only a final byte waits, and o_stall rises
//   once the input register holds it.

module utf8_text_validator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_last_byte,
    // verdict output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_verdict,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [utv_pkg::APB_AW-1:0]    paddr,
    input  logic [utv_pkg::APB_DW-1:0]    pwdata,
    output logic [utv_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    // ---------------- configuration ----------------
    logic [utv_pkg::LEN_W-1:0] max_length;

    utv_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (max_length)
    );

    // ---------------- input register ----------------
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // ---------------- text state ----------------
    logic [utv_pkg::COUNT_BITS-1:0] r_count;
    logic [utv_pkg::COUNT_BITS-1:0] n_count;
    utv_pkg::t_seq_state            r_seq;
    utv_pkg::t_seq_state            n_seq;
    utv_pkg::t_verdict              r_first_err;
    utv_pkg::t_verdict              n_first_err;

    // ---------------- output register ----------------
    logic              r_out_valid;
    logic              n_out_valid;
    utv_pkg::t_verdict r_out_verdict;
    utv_pkg::t_verdict n_out_verdict;

    // Handshake: the output slot is free when empty or being taken. A
    // non-final byte never needs the slot, so it always moves on.
    logic out_free;
    logic chk_go;
    logic in_ready;
    logic in_xfer;

    assign out_free = !r_out_valid || !i_stall;
    assign chk_go   = r_in_valid && (!r_in_last || out_free);
    assign in_ready = !r_in_valid || chk_go;
    assign in_xfer  = i_valid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // ---------------- check stage ----------------
    utv_pkg::t_verdict   chk_err;
    utv_pkg::t_seq_state chk_seq;

    utv_seq_check u_check (
        .i_byte (r_in_byte),
        .i_seq  (r_seq),
        .o_err  (chk_err),
        .o_seq  (chk_seq)
    );

    logic [utv_pkg::COUNT_BITS-1:0] cnt_inc;
    utv_pkg::t_verdict              err_upd;
    utv_pkg::t_seq_state            seq_upd;
    utv_pkg::t_verdict              err_end;
    logic                           too_long;

    always_comb begin
        // saturating byte count
        cnt_inc = (&r_count) ? r_count : r_count + 1'b1;

        // after the first error, bytes are only counted
        if (r_first_err == utv_pkg::VERDICT_VALID) begin
            err_upd = chk_err;
            seq_upd = chk_seq;
        end else begin
            err_upd = r_first_err;
            seq_upd = r_seq;
        end

        // a sequence left open at end of text is invalid UTF-8
        err_end = err_upd;
        if ((err_upd == utv_pkg::VERDICT_VALID) && (seq_upd.pend != 2'd0)) begin
            err_end = utv_pkg::VERDICT_UTF8;
        end

        too_long = (utv_pkg::CMP_W'(cnt_inc) > utv_pkg::CMP_W'(max_length));

        n_count       = r_count;
        n_seq         = r_seq;
        n_first_err   = r_first_err;
        n_out_valid   = r_out_valid && i_stall;
        n_out_verdict = r_out_verdict;

        if (chk_go) begin
            if (r_in_last) begin
                // verdict out, text state back to its reset value
                n_out_valid   = 1'b1;
                n_out_verdict = too_long ? utv_pkg::VERDICT_LONG : err_end;
                n_count       = '0;
                n_seq         = '0;
                n_first_err   = utv_pkg::VERDICT_VALID;
            end else begin
                n_count     = cnt_inc;
                n_seq       = seq_upd;
                n_first_err = err_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_seq       <= '0;
            r_first_err <= utv_pkg::VERDICT_VALID;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_seq       <= n_seq;
            r_first_err <= n_first_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_verdict <= n_out_verdict;
    end

    assign o_stall   = !in_ready;
    assign o_valid   = r_out_valid;
    assign o_verdict = r_out_verdict;

endmodule

// ===== rtl/utv_checker.sv =====
`timescale 1ns / 1ps
// utv_checker: port-level assertions for utf8_text_validator, bound to it.
// Depends on utv_pkg.

module utv_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [7:0]                    i_data_byte,
    input logic                          i_last_byte,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [2:0]                    o_verdict,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [utv_pkg::APB_AW-1:0]    paddr,
    input logic [utv_pkg::APB_DW-1:0]    pwdata,
    input logic [utv_pkg::APB_DW-1:0]    prdata,
    input logic                          pready
);

    // stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_verdict))
        else $error("verdict changed under stall");

    // reset empties both registers
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    // no backpressure unless a verdict is waiting
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with free output slot");

    // verdict codes stay in range
    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_verdict <= 3'(utv_pkg::VERDICT_UTF8)))
        else $error("verdict code out of range");

    // max_length write reads back
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready
            && (paddr[2] == utv_pkg::REG_IDX_MAX_LENGTH))
        ##1 (psel && !pwrite && (paddr[2] == utv_pkg::REG_IDX_MAX_LENGTH))
        |-> (prdata[utv_pkg::LEN_W-1:0] == $past(pwdata[utv_pkg::LEN_W-1:0])))
        else $error("max_length readback mismatch");

endmodule

bind utf8_text_validator utv_checker u_utv_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for utf8_text_validator.
// Depends on utv_pkg and the validator RTL; drives bytes, max_length over APB
// and checks each verdict against an in-bench model of the text checker.

module tb_top;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int              CYCLE_LIMIT   = 400000;  // hard stop for a hung run
    localparam int              DRAIN_LIMIT   = 2000;    // wait for outstanding verdicts
    localparam int              SETTLE_CYCLES = 6;       // margin beyond the byte-to-verdict path
    localparam int              HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int              REPORT_CAP    = 40;      // printed mismatch lines

    localparam int              REG_MAX_LENGTH = 0;      // register index
    localparam logic [utv_pkg::APB_AW-1:0] ADDR_MAX_LENGTH =
        utv_pkg::APB_AW'(4 * REG_MAX_LENGTH);
    localparam logic [24:0]     LEN_AT_RESET  = 25'd1048576;
    localparam logic [24:0]     LEN_TOP       = 25'd16777216;
    localparam logic [24:0]     COUNT_CEIL    = '1;      // saturating byte count

    // Byte values of the strict UTF-8 rules
    localparam logic [7:0] B_NUL   = 8'h00;
    localparam logic [7:0] B_TAB   = 8'h09;
    localparam logic [7:0] B_LF    = 8'h0a;
    localparam logic [7:0] B_CR    = 8'h0d;
    localparam logic [7:0] B_SPACE = 8'h20;
    localparam logic [7:0] B_DEL   = 8'h7f;
    localparam logic [7:0] B_ASCII = 8'h80;
    localparam logic [7:0] L2_MIN  = 8'hc2;
    localparam logic [7:0] L2_MAX  = 8'hdf;
    localparam logic [7:0] L3_MIN  = 8'he0;
    localparam logic [7:0] L3_MAX  = 8'hef;
    localparam logic [7:0] L4_MIN  = 8'hf0;
    localparam logic [7:0] L4_MAX  = 8'hf4;
    localparam logic [7:0] L_SURR  = 8'hed;
    localparam logic [7:0] C_MIN   = 8'h80;
    localparam logic [7:0] C_MAX   = 8'hbf;
    localparam logic [7:0] E0_LOW  = 8'ha0;  // first legal byte after E0
    localparam logic [7:0] ED_HIGH = 8'h9f;  // last legal byte after ED
    localparam logic [7:0] F0_LOW  = 8'h90;  // first legal byte after F0
    localparam logic [7:0] F4_HIGH = 8'h8f;  // last legal byte after F4

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_byte;

    // ------------------------------------------------------------------
    // DUT connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic [7:0]                    i_data_byte = '0;
    logic                          i_last_byte = 1'b0;
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic [2:0]                    o_verdict;
    logic                          psel        = 1'b0;
    logic                          penable     = 1'b0;
    logic                          pwrite      = 1'b0;
    logic [utv_pkg::APB_AW-1:0]    paddr       = '0;
    logic [utv_pkg::APB_DW-1:0]    pwdata      = '0;
    logic [utv_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    utf8_text_validator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_verdict   (o_verdict),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_text_byte          pending_bytes[$];      // bytes not yet offered to the DUT
    utv_pkg::t_verdict   expected_verdicts[$];  // one per accepted final byte
    logic [7:0]          text_buf[$];           // scratch for building one text
    t_text_byte          drv_item;

    int          send_idle_pct = 0;     // chance the sender skips a cycle
    int          stall_pct     = 0;     // chance the receiver stalls
    logic        hold_req      = 1'b0;  // asks for the one long hold-off
    int          hold_count    = 0;
    int          fail_count    = 0;
    int          cycle_count   = 0;

    // Text checker state, mirrors the block
    logic [24:0]       max_len_cfg = LEN_AT_RESET;
    logic [24:0]       txt_count   = '0;
    logic [1:0]        seq_pend    = '0;
    logic [7:0]        seq_lead    = '0;
    logic              seq_second  = 1'b0;
    utv_pkg::t_verdict txt_error   = utv_pkg::VERDICT_VALID;

    task automatic report_mismatch(input string msg);
        if (fail_count < REPORT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Text checker
    // ------------------------------------------------------------------

    // Classifies one byte and advances the open-sequence state.
    function automatic utv_pkg::t_verdict classify_byte(input logic [7:0] b);
        logic bad;
        if (seq_pend != 2'd0) begin
            // inside a sequence only the continuation form matters,
            // so NUL or control bytes here count as bad UTF-8
            bad = (b[7:6] != 2'b10);
            if (seq_second) begin
                if (seq_lead == L3_MIN && b < E0_LOW)  bad = 1'b1;  // overlong
                if (seq_lead == L_SURR && b > ED_HIGH) bad = 1'b1;  // surrogate
                if (seq_lead == L4_MIN && b < F0_LOW)  bad = 1'b1;  // overlong
                if (seq_lead == L4_MAX && b > F4_HIGH) bad = 1'b1;  // > U+10FFFF
            end
            if (bad)
                return utv_pkg::VERDICT_UTF8;
            seq_pend   = seq_pend - 2'd1;
            seq_second = 1'b0;
            return utv_pkg::VERDICT_VALID;
        end
        if (b == B_NUL)
            return utv_pkg::VERDICT_NUL;
        if (b < B_ASCII) begin
            if (b == B_DEL || (b < B_SPACE && b != B_TAB && b != B_CR && b != B_LF))
                return utv_pkg::VERDICT_CTRL;
            return utv_pkg::VERDICT_VALID;
        end
        if (b >= L2_MIN && b <= L2_MAX)      seq_pend = 2'd1;
        else if (b >= L3_MIN && b <= L3_MAX) seq_pend = 2'd2;
        else if (b >= L4_MIN && b <= L4_MAX) seq_pend = 2'd3;
        else return utv_pkg::VERDICT_UTF8;
        seq_lead   = b;
        seq_second = 1'b1;
        return utv_pkg::VERDICT_VALID;
    endfunction

    // Called for every accepted byte; queues the verdict on a final byte.
    task automatic track_text_byte(input logic [7:0] b, input logic last);
        utv_pkg::t_verdict v;
        if (txt_count != COUNT_CEIL)
            txt_count = txt_count + 25'd1;
        // first error sticks; later bytes are only counted
        if (txt_error == utv_pkg::VERDICT_VALID)
            txt_error = classify_byte(b);
        if (last) begin
            // sequence cut short by the end of the text
            if (txt_error == utv_pkg::VERDICT_VALID && seq_pend != 2'd0)
                txt_error = utv_pkg::VERDICT_UTF8;
            // excess length outranks everything else
            v = (txt_count > max_len_cfg) ? utv_pkg::VERDICT_LONG : txt_error;
            expected_verdicts.push_back(v);
            txt_count  = '0;
            seq_pend   = '0;
            seq_lead   = '0;
            seq_second = 1'b0;
            txt_error  = utv_pkg::VERDICT_VALID;
        end
    endtask

    // ------------------------------------------------------------------
    // Byte driver: offers queued bytes, holds the payload while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall)
                track_text_byte(i_data_byte, i_last_byte);
            // free to move on when nothing is on the bus or it just transferred
            if (!i_valid || !o_stall) begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_item = pending_bytes.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= drv_item.data;
                    i_last_byte <= drv_item.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random, plus one long hold-off when asked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && hold_count < HOLD_CYCLES) begin
            // sender keeps offering; the block has to back up and stall
            i_stall    <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Verdict monitor
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict %0d with no text outstanding", o_verdict));
            end else if (o_verdict !== expected_verdicts[0]) begin
                report_mismatch($sformatf("verdict %0d, expected %0d",
                                          o_verdict, expected_verdicts[0]));
                void'(expected_verdicts.pop_front());
            end else begin
                void'(expected_verdicts.pop_front());
            end
        end
    end

    // Hung-run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    task automatic set_pacing(input int idle_pct, input int stall_in_pct);
        @(posedge i_clk);
        send_idle_pct <= idle_pct;
        stall_pct     <= stall_in_pct;
    endtask

    // APB write then read back; only called with the block idle.
    task automatic write_max_length(input logic [24:0] value);
        logic [utv_pkg::APB_DW-1:0] seen;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LENGTH;
        pwdata  <= utv_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);               // register takes the value here
        psel    <= 1'b0;
        penable <= 1'b0;
        max_len_cfg = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        seen = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== utv_pkg::APB_DW'(value))
            report_mismatch($sformatf("max_length reads %0d, wrote %0d", seen, value));
    endtask

    // Waits for the input side to empty, then for all verdicts, then settles.
    task automatic drain_results();
        int waited;
        waited = 0;
        do @(negedge i_clk); while (pending_bytes.size() != 0 || i_valid);
        while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_verdicts.size() != 0) begin
            report_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
            expected_verdicts.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        pending_bytes.push_back('{data: b, last: last});
    endtask

    // Continuation byte in [lo, hi], biased toward the two ends.
    function automatic logic [7:0] pick_in(input logic [7:0] lo, input logic [7:0] hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return 8'($urandom_range(hi, lo));
        endcase
    endfunction

    // Appends one well-formed character.
    task automatic add_char();
        int         r;
        logic [7:0] lead;
        r = $urandom_range(99);
        if (r < 40) begin
            text_buf.push_back(8'($urandom_range(8'h7e, B_SPACE)));
        end else if (r < 46) begin
            case ($urandom_range(2))
                0:       text_buf.push_back(B_TAB);
                1:       text_buf.push_back(B_LF);
                default: text_buf.push_back(B_CR);
            endcase
        end else if (r < 64) begin
            text_buf.push_back(pick_in(L2_MIN, L2_MAX));
            text_buf.push_back(pick_in(C_MIN, C_MAX));
        end else if (r < 84) begin
            // lean on E0 and ED, whose second byte is range-limited
            case ($urandom_range(3))
                0:       lead = L3_MIN;
                1:       lead = L_SURR;
                default: lead = 8'($urandom_range(L3_MAX, L3_MIN));
            endcase
            text_buf.push_back(lead);
            if (lead == L3_MIN)      text_buf.push_back(pick_in(E0_LOW, C_MAX));
            else if (lead == L_SURR) text_buf.push_back(pick_in(C_MIN, ED_HIGH));
            else                     text_buf.push_back(pick_in(C_MIN, C_MAX));
            text_buf.push_back(pick_in(C_MIN, C_MAX));
        end else begin
            case ($urandom_range(3))
                0:       lead = L4_MIN;
                1:       lead = L4_MAX;
                default: lead = 8'($urandom_range(L4_MAX, L4_MIN));
            endcase
            text_buf.push_back(lead);
            if (lead == L4_MIN)      text_buf.push_back(pick_in(F0_LOW, C_MAX));
            else if (lead == L4_MAX) text_buf.push_back(pick_in(C_MIN, F4_HIGH));
            else                     text_buf.push_back(pick_in(C_MIN, C_MAX));
            text_buf.push_back(pick_in(C_MIN, C_MAX));
            text_buf.push_back(pick_in(C_MIN, C_MAX));
        end
    endtask

    // Builds one text, mostly well formed, and queues it. Returns its length.
    task automatic queue_text(input int max_chars, output int n_bytes);
        int n_chars;
        int r;
        text_buf.delete();
        if (max_chars > 8 && $urandom_range(9) == 0)
            n_chars = $urandom_range(max_chars, 9);
        else
            n_chars = $urandom_range((max_chars < 8) ? max_chars : 8, 1);
        for (int i = 0; i < n_chars; i++)
            add_char();
        r = $urandom_range(99);
        if (r < 12) begin
            // any byte value at a random spot
            text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
        end else if (r < 18) begin
            // sequence cut short by the end of the text
            text_buf.push_back(pick_in(L3_MIN, L4_MAX));
            if ($urandom_range(1))
                text_buf.push_back(pick_in(F0_LOW, C_MAX));
        end else if (r < 25) begin
            // NUL, DEL or a control byte, possibly inside a sequence
            case ($urandom_range(2))
                0:       text_buf.insert($urandom_range(text_buf.size()), B_NUL);
                1:       text_buf.insert($urandom_range(text_buf.size()), B_DEL);
                default: text_buf.insert($urandom_range(text_buf.size()),
                                         8'($urandom_range(8'h1f, 8'h01)));
            endcase
        end
        n_bytes = text_buf.size();
        for (int i = 0; i < n_bytes; i++)
            push_byte(text_buf[i], i == n_bytes - 1);
    endtask

    task automatic queue_random_texts(input int byte_goal, input int max_chars);
        int added;
        int n;
        added = 0;
        while (added < byte_goal) begin
            queue_text(max_chars, n);
            added += n;
        end
    endtask

    // Hand-picked texts: field extremes and special cases.
    task automatic queue_directed();
        push_byte(8'h41, 1'b1);                                       // plain ASCII
        push_byte(B_NUL, 1'b1);                                       // NUL
        push_byte(B_DEL, 1'b1);                                       // DEL
        push_byte(B_TAB, 1'b0); push_byte(B_CR, 1'b0); push_byte(B_LF, 1'b1);
        push_byte(L2_MIN, 1'b0); push_byte(C_MIN, 1'b1);              // shortest 2-byte
        push_byte(8'hff, 1'b1);                                       // never a lead
        // E0 overlong; the trailing byte is only counted
        push_byte(L3_MIN, 1'b0); push_byte(8'h9f, 1'b0); push_byte(C_MIN, 1'b1);
        push_byte(L_SURR, 1'b0); push_byte(E0_LOW, 1'b1);             // surrogate
        push_byte(L4_MAX, 1'b0); push_byte(F0_LOW, 1'b1);             // above U+10FFFF
        push_byte(L4_MIN, 1'b0); push_byte(F4_HIGH, 1'b1);            // F0 overlong
        push_byte(8'he2, 1'b0); push_byte(8'h82, 1'b1);               // truncated
        push_byte(L2_MIN, 1'b0); push_byte(B_NUL, 1'b1);              // NUL mid-sequence
        push_byte(8'h01, 1'b0); push_byte(B_NUL, 1'b1);               // first error sticks
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length limit, no idling
        set_pacing(0, 0);
        queue_directed();
        drain_results();

        // zero limit: every text is too long
        write_max_length('0);
        queue_random_texts(120, 12);
        drain_results();

        // random limit, sender mostly idle
        write_max_length(25'($urandom_range(LEN_TOP)));
        set_pacing(64, 0);
        queue_random_texts(170, 20);
        drain_results();

        // limit of one byte, receiver mostly stalled
        write_max_length(25'd1);
        set_pacing(0, 64);
        queue_random_texts(170, 12);
        drain_results();

        // small limit near typical text lengths, both sides idling
        write_max_length(25'($urandom_range(12, 2)));
        set_pacing(25, 25);
        queue_random_texts(170, 20);
        drain_results();

        // limit of 16777216; receiver holds off while short texts keep coming
        write_max_length(LEN_TOP);
        set_pacing(0, 0);
        @(posedge i_clk);
        hold_req <= 1'b1;
        queue_random_texts(170, 2);
        drain_results();

        // another limit, full rate
        write_max_length(25'($urandom_range(40)));
        queue_random_texts(170, 30);
        drain_results();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
